[design/tbfi_pkg.sv]
package tbfi_pkg;

  // Default table length and number of bond types.
  localparam int TABLE_WIDTH_DEF = 1024;
  localparam int NUM_TYPES_DEF   = 4;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RANGE = 2'd1,
    OP_BOND  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OUT_RANGE = 2'd1,
    ST_REJECTED  = 2'd2
  } status_e;

  // Item fields that travel down the pipeline with each item.
  typedef struct packed {
    op_e                op;
    logic [1:0]         typ;
    logic [9:0]         entry;
    logic signed [31:0] ev;
    logic signed [31:0] fv;
    logic [30:0]        rmin;
    logic [30:0]        rmax;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    status_e            st;
    logic               zr;
  } sb_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [31:0] res;
    if (x > 65'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (x < -65'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

[design/tabulated_bond_force_interp_unit.sv]
// Tabulated bond force unit with linear interpolation. The unit takes one item in every
// cycle and never stalls: busy stays low, and each item gives one result on the result
// ports, marked by done_o for exactly one cycle, in the order in which the items were taken.
// The receiver cannot hold results off, so it must take each one in the cycle where done_o
// is high. The pipeline holds the 32-step square root, the bin divider with one step per
// quotient bit, and the 32-step divider that scales the force by the distance; table writes
// and range updates take effect in item order at their own pipeline stage, so items may
// follow each other freely.
module tabulated_bond_force_interp_unit #(
  parameter int TABLE_WIDTH = tbfi_pkg::TABLE_WIDTH_DEF,
  parameter int NUM_TYPES   = tbfi_pkg::NUM_TYPES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [1:0]         bond_type_i,
  input  logic [9:0]         entry_index_i,
  input  logic signed [31:0] energy_value_i,
  input  logic signed [31:0] force_value_i,
  input  logic [30:0]        range_min_i,
  input  logic [30:0]        range_max_i,
  input  logic signed [31:0] disp_x_i,
  input  logic signed [31:0] disp_y_i,
  input  logic signed [31:0] disp_z_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [31:0] half_energy_o,
  output logic signed [31:0] virial_xx_o,
  output logic signed [31:0] virial_xy_o,
  output logic signed [31:0] virial_xz_o,
  output logic signed [31:0] virial_yy_o,
  output logic signed [31:0] virial_yz_o,
  output logic signed [31:0] virial_zz_o
);

  localparam int IDX_W  = $clog2(TABLE_WIDTH);
  localparam int P_W    = 31 + IDX_W;
  localparam int QW     = IDX_W + 16;
  localparam int DEPTH  = NUM_TYPES * TABLE_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_WIDTH - 2);

  assign busy = 1'b0;

  // ---------------------------------------------------------------- input stage
  logic       v0_q;
  tbfi_pkg::sb_t sb0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    sb0_q.op    <= tbfi_pkg::op_e'(op_i);
    sb0_q.typ   <= bond_type_i;
    sb0_q.entry <= entry_index_i;
    sb0_q.ev    <= energy_value_i;
    sb0_q.fv    <= force_value_i;
    sb0_q.rmin  <= range_min_i;
    sb0_q.rmax  <= range_max_i;
    sb0_q.dx    <= disp_x_i;
    sb0_q.dy    <= disp_y_i;
    sb0_q.dz    <= disp_z_i;
    sb0_q.st    <= tbfi_pkg::ST_OK;
    sb0_q.zr    <= 1'b0;
  end

  // ---------------------------------------------------------------- squares
  logic               v1_q, v2_q;
  tbfi_pkg::sb_t      sb1_q, sb2_q;
  logic signed [63:0] sqx_q, sqy_q, sqz_q;
  logic [63:0]        rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // The sum of three squares of 32-bit values always fits in 64 bits.
  always_ff @(posedge clk_i) begin
    sb1_q <= sb0_q;
    sqx_q <= sb0_q.dx * sb0_q.dx;
    sqy_q <= sb0_q.dy * sb0_q.dy;
    sqz_q <= sb0_q.dz * sb0_q.dz;
    sb2_q <= sb1_q;
    rsq_q <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
  end

  // ---------------------------------------------------------------- square root
  // One result bit per stage: two radicand bits come down, a trial subtract decides the bit.
  logic          sr_v_q    [32];
  tbfi_pkg::sb_t sr_sb_q   [32];
  logic [34:0]   sr_rem_q  [32];
  logic [31:0]   sr_root_q [32];
  logic [63:0]   sr_rad_q  [32];

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic          in_v;
    tbfi_pkg::sb_t in_sb;
    logic [34:0]   in_rem, rem2, trial;
    logic [31:0]   in_root;
    logic [63:0]   in_rad;

    if (k == 0) begin : g_first
      assign in_v    = v2_q;
      assign in_sb   = sb2_q;
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_rad  = rsq_q;
    end else begin : g_next
      assign in_v    = sr_v_q[k-1];
      assign in_sb   = sr_sb_q[k-1];
      assign in_rem  = sr_rem_q[k-1];
      assign in_root = sr_root_q[k-1];
      assign in_rad  = sr_rad_q[k-1];
    end

    assign rem2  = {in_rem[32:0], in_rad[63:62]};
    assign trial = {1'b0, in_root, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k] <= 1'b0;
      end else begin
        sr_v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      sr_sb_q[k]  <= in_sb;
      sr_rad_q[k] <= {in_rad[61:0], 2'b00};
      if (rem2 >= trial) begin
        sr_rem_q[k]  <= rem2 - trial;
        sr_root_q[k] <= {in_root[30:0], 1'b1};
      end else begin
        sr_rem_q[k]  <= rem2;
        sr_root_q[k] <= {in_root[30:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------- range stage
  // Range writes and range reads both happen here, so they stay in item order.
  logic [30:0] rlo_q  [NUM_TYPES];
  logic [30:0] rhi_q  [NUM_TYPES];
  logic [30:0] rspn_q [NUM_TYPES];

  tbfi_pkg::sb_t sbr, sb3_q;
  logic [31:0]   rr;
  logic [TIDX_W-1:0] tsel;
  logic          tok, inr, rng_ok;
  logic [30:0]   lo_s, hi_s, spn_s;
  logic          v3_q;
  logic [31:0]   r3_q;
  logic [30:0]   diff3_q, span3_q;

  assign sbr    = sr_sb_q[31];
  assign rr     = sr_root_q[31];
  assign tsel   = TIDX_W'(sbr.typ);
  assign tok    = 32'(sbr.typ) < NUM_TYPES;
  assign rng_ok = sbr.rmin < sbr.rmax;

  always_comb begin
    lo_s  = '0;
    hi_s  = '0;
    spn_s = '0;
    if (tok) begin
      lo_s  = rlo_q[tsel];
      hi_s  = rhi_q[tsel];
      spn_s = rspn_q[tsel];
    end
    inr = tok && (rr >= {1'b0, lo_s}) && (rr < {1'b0, hi_s}) && (spn_s != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        rlo_q[t]  <= '0;
        rhi_q[t]  <= '0;
        rspn_q[t] <= '0;
      end
    end else if (sr_v_q[31] && sbr.op == tbfi_pkg::OP_RANGE && rng_ok && tok) begin
      rlo_q[tsel]  <= sbr.rmin;
      rhi_q[tsel]  <= sbr.rmax;
      rspn_q[tsel] <= sbr.rmax - sbr.rmin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sr_v_q[31];
    end
  end

  always_ff @(posedge clk_i) begin
    sb3_q    <= sbr;
    sb3_q.zr <= (rr == '0);
    case (sbr.op)
      tbfi_pkg::OP_RANGE: sb3_q.st <= rng_ok ? tbfi_pkg::ST_OK : tbfi_pkg::ST_REJECTED;
      tbfi_pkg::OP_BOND:  sb3_q.st <= inr ? tbfi_pkg::ST_OK : tbfi_pkg::ST_OUT_RANGE;
      default:            sb3_q.st <= tbfi_pkg::ST_OK;
    endcase
    r3_q    <= rr;
    diff3_q <= rr[30:0] - lo_s;
    span3_q <= spn_s;
  end

  // ---------------------------------------------------------------- bin scaling
  logic          v4_q;
  tbfi_pkg::sb_t sb4_q;
  logic [31:0]   r4_q;
  logic [30:0]   span4_q;
  logic [P_W-1:0] p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb4_q   <= sb3_q;
    r4_q    <= r3_q;
    span4_q <= span3_q;
    p4_q    <= P_W'(diff3_q) * P_W'(TABLE_WIDTH - 1);
  end

  // ---------------------------------------------------------------- bin divider
  // Divides p * 2^16 by the span; the quotient holds the bin index and the 16-bit fraction.
  // The quotient is known to fit in QW bits, so the top bits start out below the span.
  logic          dv_v_q    [QW];
  tbfi_pkg::sb_t dv_sb_q   [QW];
  logic [31:0]   dv_r_q    [QW];
  logic [30:0]   dv_span_q [QW];
  logic [30:0]   dv_rem_q  [QW];
  logic [QW-1:0] dv_low_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_bdiv
    logic          in_v;
    tbfi_pkg::sb_t in_sb;
    logic [31:0]   in_r;
    logic [30:0]   in_span, in_rem;
    logic [QW-1:0] in_low;
    logic [31:0]   t;

    if (k == 0) begin : g_first
      assign in_v    = v4_q;
      assign in_sb   = sb4_q;
      assign in_r    = r4_q;
      assign in_span = span4_q;
      assign in_rem  = p4_q[P_W-1:IDX_W];
      assign in_low  = {p4_q[IDX_W-1:0], 16'h0000};
    end else begin : g_next
      assign in_v    = dv_v_q[k-1];
      assign in_sb   = dv_sb_q[k-1];
      assign in_r    = dv_r_q[k-1];
      assign in_span = dv_span_q[k-1];
      assign in_rem  = dv_rem_q[k-1];
      assign in_low  = dv_low_q[k-1];
    end

    assign t = {in_rem, in_low[QW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else begin
        dv_v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_sb_q[k]   <= in_sb;
      dv_r_q[k]    <= in_r;
      dv_span_q[k] <= in_span;
      if (t >= {1'b0, in_span}) begin
        dv_rem_q[k] <= 31'(t - {1'b0, in_span});
        dv_low_q[k] <= {in_low[QW-2:0], 1'b1};
      end else begin
        dv_rem_q[k] <= t[30:0];
        dv_low_q[k] <= {in_low[QW-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------- table stage
  // Table writes and reads share this stage, so a bond sees every earlier write.
  logic signed [31:0] emem [DEPTH];
  logic signed [31:0] fmem [DEPTH];

  tbfi_pkg::sb_t   sbm;
  logic [QW-1:0]   qm;
  logic [IDX_W-1:0] idx_raw, idx_c;
  logic [AW-1:0]   base, ra0, ra1, wa;
  logic            mtok, we;

  assign sbm     = dv_sb_q[QW-1];
  assign qm      = dv_low_q[QW-1];
  assign idx_raw = qm[QW-1:16];
  assign idx_c   = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
  assign mtok    = 32'(sbm.typ) < NUM_TYPES;
  assign base    = AW'(32'(sbm.typ) * TABLE_WIDTH);
  assign ra0     = base + AW'(idx_c);
  assign ra1     = ra0 + AW'(1);
  assign wa      = base + AW'(sbm.entry);
  assign we      = dv_v_q[QW-1] && sbm.op == tbfi_pkg::OP_WRITE && mtok &&
                   (32'(sbm.entry) < TABLE_WIDTH);

  logic               v5_q;
  tbfi_pkg::sb_t      sb5_q;
  logic [31:0]        r5_q;
  logic [15:0]        frac5_q;
  logic signed [31:0] e0_q, e1_q, f0_q, f1_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      emem[wa] <= sbm.ev;
      fmem[wa] <= sbm.fv;
    end
    e0_q <= emem[ra0];
    e1_q <= emem[ra1];
    f0_q <= fmem[ra0];
    f1_q <= fmem[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dv_v_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb5_q   <= sbm;
    r5_q    <= dv_r_q[QW-1];
    frac5_q <= qm[15:0];
  end

  // ---------------------------------------------------------------- interpolation
  logic               v6_q, v7_q;
  tbfi_pkg::sb_t      sb6_q, sb7_q;
  logic [31:0]        r6_q, r7_q;
  logic signed [49:0] pe6_q, pf6_q;
  logic signed [31:0] e06_q, f06_q;
  logic signed [32:0] de, df;
  logic signed [33:0] vsum, fsum;
  logic signed [31:0] half7_q, f7_q;

  assign de   = 33'(e1_q) - 33'(e0_q);
  assign df   = 33'(f1_q) - 33'(f0_q);
  assign vsum = 34'(e06_q) + 34'(pe6_q >>> 16);
  assign fsum = 34'(f06_q) + 34'(pf6_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb6_q   <= sb5_q;
    r6_q    <= r5_q;
    e06_q   <= e0_q;
    f06_q   <= f0_q;
    pe6_q   <= $signed({1'b0, frac5_q}) * de;
    pf6_q   <= $signed({1'b0, frac5_q}) * df;
    sb7_q   <= sb6_q;
    r7_q    <= r6_q;
    half7_q <= vsum[32:1];
    f7_q    <= fsum[31:0];
  end

  // ---------------------------------------------------------------- force numerators
  logic               v8_q, v9_q;
  tbfi_pkg::sb_t      sb8_q, sb9_q;
  logic [31:0]        r8_q, r9_q;
  logic signed [31:0] half8_q, half9_q;
  logic signed [63:0] fd8_q [3];
  logic [63:0]        mag9_q [3];
  logic               neg9_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Magnitude and sign split ahead of the unsigned divider.
  always_ff @(posedge clk_i) begin
    sb8_q    <= sb7_q;
    r8_q     <= r7_q;
    half8_q  <= half7_q;
    fd8_q[0] <= f7_q * sb7_q.dx;
    fd8_q[1] <= f7_q * sb7_q.dy;
    fd8_q[2] <= f7_q * sb7_q.dz;
    sb9_q    <= sb8_q;
    r9_q     <= r8_q;
    half9_q  <= half8_q;
    for (int l = 0; l < 3; l++) begin
      neg9_q[l] <= fd8_q[l][63];
      mag9_q[l] <= fd8_q[l][63] ? 64'(-fd8_q[l]) : 64'(fd8_q[l]);
    end
  end

  // ---------------------------------------------------------------- force divider
  // Three lanes divide |F * d| by r, one quotient bit per stage. Since |d| <= r the
  // quotient fits in 32 bits and the upper half of the dividend starts below r.
  logic               fq_v_q    [32];
  tbfi_pkg::sb_t      fq_sb_q   [32];
  logic [31:0]        fq_r_q    [32];
  logic signed [31:0] fq_half_q [32];
  logic [31:0]        fq_rem_q  [32][3];
  logic [31:0]        fq_low_q  [32][3];
  logic               fq_neg_q  [32][3];

  for (genvar k = 0; k < 32; k++) begin : g_fdiv
    logic               in_v;
    tbfi_pkg::sb_t      in_sb;
    logic [31:0]        in_r;
    logic signed [31:0] in_half;

    if (k == 0) begin : g_first
      assign in_v    = v9_q;
      assign in_sb   = sb9_q;
      assign in_r    = r9_q;
      assign in_half = half9_q;
    end else begin : g_next
      assign in_v    = fq_v_q[k-1];
      assign in_sb   = fq_sb_q[k-1];
      assign in_r    = fq_r_q[k-1];
      assign in_half = fq_half_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fq_v_q[k] <= 1'b0;
      end else begin
        fq_v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      fq_sb_q[k]   <= in_sb;
      fq_r_q[k]    <= in_r;
      fq_half_q[k] <= in_half;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [31:0] in_rem, in_low;
      logic        in_neg;
      logic [32:0] t;

      if (k == 0) begin : g_first
        assign in_rem = mag9_q[l][63:32];
        assign in_low = mag9_q[l][31:0];
        assign in_neg = neg9_q[l];
      end else begin : g_next
        assign in_rem = fq_rem_q[k-1][l];
        assign in_low = fq_low_q[k-1][l];
        assign in_neg = fq_neg_q[k-1][l];
      end

      assign t = {in_rem, in_low[31]};

      always_ff @(posedge clk_i) begin
        fq_neg_q[k][l] <= in_neg;
        if (t >= {1'b0, in_r}) begin
          fq_rem_q[k][l] <= 32'(t - {1'b0, in_r});
          fq_low_q[k][l] <= {in_low[30:0], 1'b1};
        end else begin
          fq_rem_q[k][l] <= t[31:0];
          fq_low_q[k][l] <= {in_low[30:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- signed force
  logic               v10_q, v11_q;
  tbfi_pkg::sb_t      sb10_q, sb11_q;
  logic signed [31:0] half10_q, half11_q;
  logic signed [32:0] fk10_q [3];
  logic signed [31:0] frc11_q [3];
  logic signed [64:0] vp11_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      v10_q <= fq_v_q[31];
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb10_q   <= fq_sb_q[31];
    half10_q <= fq_half_q[31];
    for (int l = 0; l < 3; l++) begin
      fk10_q[l] <= fq_neg_q[31][l] ? -$signed({1'b0, fq_low_q[31][l]})
                                   : $signed({1'b0, fq_low_q[31][l]});
    end
    sb11_q   <= sb10_q;
    half11_q <= half10_q;
    for (int l = 0; l < 3; l++) begin
      frc11_q[l] <= tbfi_pkg::sat32(65'(fk10_q[l]));
    end
    vp11_q[0] <= sb10_q.dx * fk10_q[0];
    vp11_q[1] <= sb10_q.dx * fk10_q[1];
    vp11_q[2] <= sb10_q.dx * fk10_q[2];
    vp11_q[3] <= sb10_q.dy * fk10_q[1];
    vp11_q[4] <= sb10_q.dy * fk10_q[2];
    vp11_q[5] <= sb10_q.dz * fk10_q[2];
  end

  // ---------------------------------------------------------------- result register
  logic done_q;
  logic res_ok, res_frc;

  assign res_ok  = sb11_q.op == tbfi_pkg::OP_BOND && sb11_q.st == tbfi_pkg::ST_OK;
  assign res_frc = res_ok && !sb11_q.zr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o      <= sb11_q.st;
    half_energy_o <= res_ok  ? half11_q   : '0;
    force_x_o     <= res_frc ? frc11_q[0] : '0;
    force_y_o     <= res_frc ? frc11_q[1] : '0;
    force_z_o     <= res_frc ? frc11_q[2] : '0;
    virial_xx_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[0] >>> 17) : '0;
    virial_xy_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[1] >>> 17) : '0;
    virial_xz_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[2] >>> 17) : '0;
    virial_yy_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[3] >>> 17) : '0;
    virial_yz_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[4] >>> 17) : '0;
    virial_zz_o   <= res_frc ? tbfi_pkg::sat32(vp11_q[5] >>> 17) : '0;
  end

  assign done_o = done_q;

endmodule

[design/tbfi_checker.sv]
module tbfi_checker #(
  parameter int TABLE_WIDTH = tbfi_pkg::TABLE_WIDTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [31:0] force_x_o,
  input logic signed [31:0] force_y_o,
  input logic signed [31:0] force_z_o,
  input logic signed [31:0] half_energy_o,
  input logic signed [31:0] virial_xx_o,
  input logic signed [31:0] virial_zz_o
);

  localparam int LATENCY = 77 + $clog2(TABLE_WIDTH) + 16;

  // Every accepted item gives its result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  // The unit never holds off a new item.
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Only defined status codes appear.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == tbfi_pkg::ST_OK || status_o == tbfi_pkg::ST_OUT_RANGE ||
                status_o == tbfi_pkg::ST_REJECTED))
    else $error("undefined status code");

  // A failed item carries zero payload.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tbfi_pkg::ST_OK) |->
      (force_x_o == 0 && force_y_o == 0 && force_z_o == 0 && half_energy_o == 0 &&
       virial_xx_o == 0 && virial_zz_o == 0))
    else $error("nonzero payload on failed item");

endmodule

bind tabulated_bond_force_interp_unit tbfi_checker #(.TABLE_WIDTH(TABLE_WIDTH)) u_tbfi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .force_x_o     (force_x_o),
  .force_y_o     (force_y_o),
  .force_z_o     (force_z_o),
  .half_energy_o (half_energy_o),
  .virial_xx_o   (virial_xx_o),
  .virial_zz_o   (virial_zz_o)
);

[verif/tabulated_bond_force_interp_unit_test.sv]
`timescale 1ns / 1ps

module tabulated_bond_force_interp_unit_test;
  import tbfi_pkg::*;

  // One input item as it is driven onto the ports.
  typedef struct {
    op_e                op;
    logic [1:0]         typ;
    logic [9:0]         entry;
    logic signed [31:0] ev;
    logic signed [31:0] fv;
    logic [30:0]        rmin;
    logic [30:0]        rmax;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } bond_item_t;

  // One result: status plus force, half energy and the six virial shares.
  typedef struct {
    logic [1:0]         st;
    logic signed [31:0] val [10];
  } bond_result_t;

  // Keeps a copy of the tables and ranges and the queue of expected results.
  class bond_scoreboard;
    logic signed [31:0] energy_mem [4096];
    logic signed [31:0] force_mem [4096];
    logic [31:0]        lo_r [4];
    logic [31:0]        hi_r [4];
    logic [31:0]        span_r [4];
    bond_result_t       pending [$];
    int                 fails;
    int                 mismatches;
    int                 status_seen [3];

    function new();
      for (int i = 0; i < 4096; i++) begin
        energy_mem[i] = '0;
        force_mem[i] = '0;
      end
      for (int t = 0; t < 4; t++) begin
        lo_r[t] = '0;
        hi_r[t] = '0;
        span_r[t] = '0;
      end
      fails = 0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [31:0] isqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Returns the table bin that a bond reads, or -1 when it is out of range.
    function int bin_of(logic [1:0] typ, logic signed [31:0] dx, logic signed [31:0] dy,
                        logic signed [31:0] dz, output logic [31:0] r);
      logic [63:0] rsq;
      logic [63:0] p;
      longint      idx;
      rsq = 64'(longint'(dx) * longint'(dx));
      rsq += 64'(longint'(dy) * longint'(dy));
      rsq += 64'(longint'(dz) * longint'(dz));
      r = isqrt(rsq);
      if (r < lo_r[typ] || r >= hi_r[typ] || span_r[typ] == 0) return -1;
      p = 64'(r - lo_r[typ]) * 64'd1023;
      idx = p / span_r[typ];
      if (idx > 1022) idx = 1022;
      return int'(idx);
    endfunction

    // Applies an accepted item to the copy of the state and queues its result.
    function void note(bond_item_t it);
      bond_result_t exp_res;
      logic [31:0]  r;
      logic [63:0]  p;
      int           idx;
      int           a0;
      longint       frac, v, f, rl;
      longint       d [3];
      longint       fk [3];
      exp_res.st = ST_OK;
      foreach (exp_res.val[i]) exp_res.val[i] = '0;
      case (it.op)
        OP_WRITE: begin
          energy_mem[it.typ * 1024 + it.entry] = it.ev;
          force_mem[it.typ * 1024 + it.entry] = it.fv;
        end
        OP_RANGE: begin
          if (it.rmin >= it.rmax) begin
            exp_res.st = ST_REJECTED;
          end else begin
            lo_r[it.typ] = it.rmin;
            hi_r[it.typ] = it.rmax;
            span_r[it.typ] = it.rmax - it.rmin;
          end
        end
        OP_BOND: begin
          idx = bin_of(it.typ, it.dx, it.dy, it.dz, r);
          if (idx < 0) begin
            exp_res.st = ST_OUT_RANGE;
          end else begin
            d[0] = it.dx;
            d[1] = it.dy;
            d[2] = it.dz;
            p = 64'(r - lo_r[it.typ]) * 64'd1023;
            frac = longint'(((p % span_r[it.typ]) << 16) / span_r[it.typ]);
            a0 = it.typ * 1024 + idx;
            v = longint'(energy_mem[a0]) +
                ((frac * (longint'(energy_mem[a0 + 1]) - longint'(energy_mem[a0]))) >>> 16);
            f = longint'(force_mem[a0]) +
                ((frac * (longint'(force_mem[a0 + 1]) - longint'(force_mem[a0]))) >>> 16);
            exp_res.val[3] = 32'(v >>> 1);
            // At zero distance the force and virial stay zero.
            if (r > 0) begin
              rl = r;
              for (int k = 0; k < 3; k++) begin
                fk[k] = (f * d[k]) / rl;
                exp_res.val[k] = 32'(sat(fk[k]));
              end
              exp_res.val[4] = 32'(sat((d[0] * fk[0]) >>> 17));
              exp_res.val[5] = 32'(sat((d[0] * fk[1]) >>> 17));
              exp_res.val[6] = 32'(sat((d[0] * fk[2]) >>> 17));
              exp_res.val[7] = 32'(sat((d[1] * fk[1]) >>> 17));
              exp_res.val[8] = 32'(sat((d[1] * fk[2]) >>> 17));
              exp_res.val[9] = 32'(sat((d[2] * fk[2]) >>> 17));
            end
          end
        end
        default: begin
        end
      endcase
      pending.push_back(exp_res);
    endfunction

    // Compares one result with the oldest expected one.
    function void check(bond_result_t got);
      bond_result_t exp_res;
      bit           bad;
      if (pending.size() == 0) begin
        fails++;
        if (mismatches < 10) $display("unexpected result, status %0d", got.st);
        mismatches++;
        return;
      end
      exp_res = pending.pop_front();
      bad = (got.st !== exp_res.st);
      foreach (got.val[i]) if (got.val[i] !== exp_res.val[i]) bad = 1;
      if (got.st < 3) status_seen[got.st]++;
      if (bad) begin
        fails++;
        if (mismatches < 10) begin
          $display("mismatch: status exp %0d got %0d", exp_res.st, got.st);
          foreach (got.val[i])
            $display("  field %0d exp %h got %h", i, exp_res.val[i], got.val[i]);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         op_i;
  logic [1:0]         bond_type_i;
  logic [9:0]         entry_index_i;
  logic signed [31:0] energy_value_i;
  logic signed [31:0] force_value_i;
  logic [30:0]        range_min_i;
  logic [30:0]        range_max_i;
  logic signed [31:0] disp_x_i;
  logic signed [31:0] disp_y_i;
  logic signed [31:0] disp_z_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] force_x_o;
  logic signed [31:0] force_y_o;
  logic signed [31:0] force_z_o;
  logic signed [31:0] half_energy_o;
  logic signed [31:0] virial_xx_o;
  logic signed [31:0] virial_xy_o;
  logic signed [31:0] virial_xz_o;
  logic signed [31:0] virial_yy_o;
  logic signed [31:0] virial_yz_o;
  logic signed [31:0] virial_zz_o;

  bond_scoreboard sb;
  bit             written [4][1024];
  int             items_sent;

  tabulated_bond_force_interp_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .bond_type_i, .entry_index_i,
    .energy_value_i, .force_value_i, .range_min_i, .range_max_i,
    .disp_x_i, .disp_y_i, .disp_z_i, .done_o, .status_o,
    .force_x_o, .force_y_o, .force_z_o, .half_energy_o,
    .virial_xx_o, .virial_xy_o, .virial_xz_o, .virial_yy_o, .virial_yz_o, .virial_zz_o
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are taken on the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    bond_result_t got;
    if (rst_ni && done_o) begin
      got.st = status_o;
      got.val[0] = force_x_o;
      got.val[1] = force_y_o;
      got.val[2] = force_z_o;
      got.val[3] = half_energy_o;
      got.val[4] = virial_xx_o;
      got.val[5] = virial_xy_o;
      got.val[6] = virial_xz_o;
      got.val[7] = virial_yy_o;
      got.val[8] = virial_yz_o;
      got.val[9] = virial_zz_o;
      sb.check(got);
    end
  end

  // Drives one item, waits for it to be taken, then idles for a random gap, which may be none.
  task automatic send(bond_item_t it);
    int roll;
    int gap;
    start <= 1'b1;
    op_i <= it.op;
    bond_type_i <= it.typ;
    entry_index_i <= it.entry;
    energy_value_i <= it.ev;
    force_value_i <= it.fv;
    range_min_i <= it.rmin;
    range_max_i <= it.rmax;
    disp_x_i <= it.dx;
    disp_y_i <= it.dy;
    disp_z_i <= it.dz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(it);
    if (it.op == OP_WRITE) written[it.typ][it.entry] = 1'b1;
    items_sent++;
    roll = $urandom_range(0, 99);
    if (roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic bond_item_t blank_item(op_e op, logic [1:0] typ);
    bond_item_t it;
    it.op = op;
    it.typ = typ;
    it.entry = $urandom;
    it.ev = $urandom;
    it.fv = $urandom;
    it.rmin = $urandom;
    it.rmax = $urandom;
    it.dx = $urandom;
    it.dy = $urandom;
    it.dz = $urandom;
    return it;
  endfunction

  function automatic logic signed [31:0] table_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  task automatic write_entry(logic [1:0] typ, logic [9:0] entry,
                             logic signed [31:0] ev, logic signed [31:0] fv);
    bond_item_t it;
    it = blank_item(OP_WRITE, typ);
    it.entry = entry;
    it.ev = ev;
    it.fv = fv;
    send(it);
  endtask

  task automatic set_range(logic [1:0] typ, logic [30:0] rmin, logic [30:0] rmax);
    bond_item_t it;
    it = blank_item(OP_RANGE, typ);
    it.rmin = rmin;
    it.rmax = rmax;
    send(it);
  endtask

  // Writes the two entries a bond will read if they are still unwritten, then sends the bond.
  task automatic bond(logic [1:0] typ, logic signed [31:0] dx, logic signed [31:0] dy,
                      logic signed [31:0] dz);
    bond_item_t  it;
    int          idx;
    logic [31:0] r;
    idx = sb.bin_of(typ, dx, dy, dz, r);
    if (idx >= 0) begin
      for (int j = idx; j <= idx + 1; j++)
        if (!written[typ][j]) write_entry(typ, j, table_value(), table_value());
    end
    it = blank_item(OP_BOND, typ);
    it.dx = dx;
    it.dy = dy;
    it.dz = dz;
    send(it);
  endtask

  // Picks a displacement whose length is at most about target, or a fully random one.
  task automatic random_bond(logic [1:0] typ);
    logic [31:0]        target;
    logic [31:0]        lo;
    logic [31:0]        hi;
    logic signed [31:0] c [3];
    logic [31:0]        rest;
    int                 perm;
    if ($urandom_range(0, 9) == 0 || sb.span_r[typ] == 0) begin
      bond(typ, $urandom, $urandom, $urandom);
    end else begin
      lo = sb.lo_r[typ];
      hi = sb.hi_r[typ];
      target = $urandom_range(lo, hi - 1);
      if ($urandom_range(0, 9) == 0) target = hi + $urandom_range(0, 1000);
      if (target[31]) target = 32'h7fff_ffff;
      c[0] = $urandom_range(0, target);
      rest = target - c[0];
      c[1] = $urandom_range(0, rest);
      c[2] = rest - c[1];
      if ($urandom_range(0, 3) == 0) begin
        c[1] = $urandom_range(0, 3);
        c[2] = 0;
        c[0] = target;
      end
      for (int k = 0; k < 3; k++) if ($urandom_range(0, 1)) c[k] = -c[k];
      perm = $urandom_range(0, 2);
      bond(typ, c[perm], c[(perm + 1) % 3], c[(perm + 2) % 3]);
    end
  endtask

  task automatic random_range(logic [1:0] typ);
    logic [30:0] a;
    logic [30:0] b;
    case ($urandom_range(0, 4))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        a = 0;
        b = $urandom_range(1, 32'h0008_0000);
      end
      2: begin
        a = $urandom_range(0, 32'h0004_0000);
        b = a + $urandom_range(1, 32'h0010_0000);
      end
      3: begin
        a = $urandom_range(0, 32'h0001_0000);
        b = a + $urandom_range(1, 2000);
      end
      default: begin
        a = $urandom_range(0, 100);
        b = 31'h7fff_ffff;
      end
    endcase
    if (a > b && $urandom_range(0, 3) != 0) set_range(typ, b, a);
    else set_range(typ, a, b);
  endtask

  // Main stimulus and end of run.
  initial begin
    int roll;
    bond_item_t it;
    sb = new();
    items_sent = 0;
    foreach (written[t, e]) written[t][e] = 1'b0;
    start <= 1'b0;
    op_i <= OP_NOP;
    bond_type_i <= '0;
    entry_index_i <= '0;
    energy_value_i <= '0;
    force_value_i <= '0;
    range_min_i <= '0;
    range_max_i <= '0;
    disp_x_i <= '0;
    disp_y_i <= '0;
    disp_z_i <= '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: unset range, rejected ranges, extremes, zero distance, idle op.
    bond(2'd0, 32'sh0001_0000, 0, 0);
    set_range(2'd1, 31'h100, 31'h100);
    set_range(2'd1, 31'h7fff_ffff, 31'h0);
    set_range(2'd0, 31'h0, 31'h0002_0000);
    write_entry(2'd0, 10'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    write_entry(2'd0, 10'd1, 32'sh8000_0000, 32'sh7fff_ffff);
    write_entry(2'd0, 10'd1023, 32'sh0001_0000, -32'sh0002_0000);
    write_entry(2'd0, 10'd1022, -32'sh0001_0000, 32'sh0003_0000);
    bond(2'd0, 0, 0, 0);
    bond(2'd0, 1, 0, 0);
    bond(2'd0, 32'sh0001_ffff, 0, 0);
    bond(2'd0, 0, -32'sh0001_fff0, 0);
    bond(2'd0, 0, 0, 32'sh0002_0000);
    set_range(2'd3, 31'h0, 31'h7fff_ffff);
    write_entry(2'd3, 10'd1022, 32'sh7fff_ffff, 32'sh7fff_ffff);
    write_entry(2'd3, 10'd1023, 32'sh8000_0000, 32'sh8000_0000);
    bond(2'd3, 32'sh7fff_fffe, 0, 0);
    bond(2'd3, 32'sh8000_0000, 0, 0);
    bond(2'd3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    bond(2'd3, 32'sh4000_0000, -32'sh4000_0000, 32'sh3000_0000);
    it = blank_item(OP_NOP, 2'd2);
    send(it);

    // Random part: mostly bonds against set ranges, with writes, range changes and idle ops.
    while (items_sent < 1550) begin
      roll = $urandom_range(0, 99);
      if (items_sent > 800 && items_sent < 806) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (roll < 65) begin
        random_bond($urandom_range(0, 3));
      end else if (roll < 85) begin
        write_entry($urandom_range(0, 3), $urandom, table_value(), table_value());
      end else if (roll < 95) begin
        random_range($urandom_range(0, 3));
      end else begin
        it = blank_item(OP_NOP, $urandom);
        send(it);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("Sent %0d items: table writes, range updates with rejects, idle ops and bonds.",
             items_sent);
    $display("Results ok %0d, out of range %0d, rejected %0d, mismatches %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.mismatches);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
